[rtl/core/rtc_atc_pkg.sv]
// Package with constants and helper functions for the RTC alarm time calculator.
package rtc_atc_pkg;

  localparam int TimeBcdWidth    = 22;
  localparam int SubsecondWidth  = 16;
  localparam int DelaySecWidth   = 17;
  localparam int DelayUsWidth    = 20;
  localparam int AlarmTimeWidth  = 24;
  localparam int AlarmSubWidth   = 28;

  localparam int InDataWidth     = 80;
  localparam int OutDataWidth    = 56;

  localparam int TodSecWidth     = 18;
  localparam int SecSumWidth     = 19;
  localparam int DaySecWidth     = 17;
  localparam int UsSumWidth      = 21;
  localparam int UsRemWidth      = 20;
  localparam int HourSecWidth    = 12;

  localparam logic [SecSumWidth-1:0] SecondsPerDay  = 19'd86400;
  localparam logic [UsSumWidth-1:0]  MicrosPerSec   = 21'd1000000;
  localparam int                     MicrosPerSecI  = 1000000;

  localparam logic [AlarmTimeWidth-1:0] TimeMaskBits = 24'h808080;
  localparam logic [AlarmSubWidth-1:0]  SubMaskBits  = 28'h0f000000;

  // Reciprocals that divide exactly over the ranges seen in the pipeline.
  localparam logic [17:0] RecipHour  = 18'd149131;
  localparam int          ShiftHour  = 29;
  localparam logic [12:0] RecipMin   = 13'd4370;
  localparam int          ShiftMin   = 18;

  // Tens digit of a value below 64.
  function automatic logic [2:0] div10(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return p[9:7];
  endfunction

  // Two BCD digits of a value below 64, tens in the upper nibble.
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] units;
    tens  = div10(v);
    units = v - 6'(tens) * 6'd10;
    return {1'b0, tens, units[3:0]};
  endfunction

endpackage

[rtl/core/rtc_alarm_time_calculator.sv]
// Top level of the RTC alarm time calculator: a seven-stage alarm offset pipeline.
//
// Each input item on the s_axis channel carries the current BCD time-of-day word,
// the subsecond down-counter and a delay in seconds and microseconds. For each one
// the m_axis channel delivers one item with the BCD alarm word, the alarm
// subsecond word and, on tuser, a flag telling that the subsecond input was
// clamped to the prescaler.
//
// A result appears on m_axis once its item has passed through every stage register.
// While no stall holds the pipeline, one item is accepted per cycle; the multiply by
// the tick length and the modulo-day reduction each own a stage, and the exact
// reciprocal divisions sit in later stages, the hour and tick divisions sharing one.
// Each stage holds a valid bit and advances when the stage after it is empty or
// advancing, so a stalled receiver fills the empty stages first and only then
// deasserts s_axis_tready_o. Nothing is dropped or repeated under stalls.
// Reset clears all valid bits; the pipeline is empty and ready right after it.
module rtc_alarm_time_calculator #(
  parameter int SUBSECOND_TICKS_PER_SECOND = 20000
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // Fields from bit 0: current_time_bcd[21:0], current_subsecond[37:22],
  // delay_seconds[54:38], delay_microseconds[74:55], zero fill[79:75].
  input  logic [rtc_atc_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // Fields from bit 0: alarm_time_word[23:0], alarm_subsecond_word[51:24],
  // zero fill[55:52].
  output logic [rtc_atc_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  // Fields from bit 0: input_clamped[0].
  output logic                                  m_axis_tuser_o
);

  localparam int NumStages = 7;
  localparam int Ticks     = SUBSECOND_TICKS_PER_SECOND;
  localparam int PW        = $clog2(Ticks);
  localparam int Upt       = rtc_atc_pkg::MicrosPerSecI / Ticks;
  localparam int RecipL    = $clog2(Upt);
  localparam int RecipK    = rtc_atc_pkg::UsRemWidth + RecipL;
  localparam longint unsigned RecipM =
      ((64'd1 << RecipK) + longint'(Upt) - 64'd1) / longint'(Upt);
  localparam int ProdW     = 2 * rtc_atc_pkg::UsRemWidth + 1;

  localparam logic [PW-1:0]    Presc   = PW'(Ticks - 1);
  localparam logic [20:0]      UptC    = 21'(Upt);
  localparam logic [ProdW-1:0] RecipMC = ProdW'(RecipM);

  logic [NumStages:1] valid_q;
  logic [NumStages:0] valid_in;
  logic [NumStages+1:1] en;

  // Stage payloads.
  logic [PW-1:0]                           s1_elapsed_q, s1_elapsed_d;
  logic [rtc_atc_pkg::DelayUsWidth-1:0]    s1_dus_q, s1_dus_d;
  logic [rtc_atc_pkg::DelaySecWidth-1:0]   s1_ds_q, s1_ds_d;
  logic [rtc_atc_pkg::TodSecWidth-1:0]     s1_todsec_q, s1_todsec_d;
  logic                                    s1_clamp_q, s1_clamp_d;

  logic [rtc_atc_pkg::UsSumWidth-1:0]      s2_us_q, s2_us_d;
  logic [rtc_atc_pkg::SecSumWidth-1:0]     s2_secsum_q, s2_secsum_d;
  logic                                    s2_clamp_q;

  logic [rtc_atc_pkg::DaySecWidth-1:0]     s3_sec_q, s3_sec_d;
  logic [rtc_atc_pkg::UsRemWidth-1:0]      s3_usrem_q, s3_usrem_d;
  logic                                    s3_clamp_q;

  logic [4:0]                              s4_hours_q, s4_hours_d;
  logic [rtc_atc_pkg::DaySecWidth-1:0]     s4_sec_q;
  logic [rtc_atc_pkg::UsRemWidth-1:0]      s4_ticks_q, s4_ticks_d;
  logic                                    s4_clamp_q;

  logic [rtc_atc_pkg::HourSecWidth-1:0]    s5_rem_q, s5_rem_d;
  logic [4:0]                              s5_hours_q;
  logic [PW-1:0]                           s5_sub_q, s5_sub_d;
  logic                                    s5_clamp_q;

  logic [5:0]                              s6_min_q, s6_min_d;
  logic [rtc_atc_pkg::HourSecWidth-1:0]    s6_rem_q;
  logic [4:0]                              s6_hours_q;
  logic [PW-1:0]                           s6_sub_q;
  logic                                    s6_clamp_q;

  logic [rtc_atc_pkg::AlarmTimeWidth-1:0]  s7_time_q, s7_time_d;
  logic [rtc_atc_pkg::AlarmSubWidth-1:0]   s7_sub_q, s7_sub_d;
  logic                                    s7_clamp_q;

  // Input fields.
  logic [rtc_atc_pkg::TimeBcdWidth-1:0]    in_tod;
  logic [rtc_atc_pkg::SubsecondWidth-1:0]  in_ss;

  // Combinational helpers.
  logic [5:0]                              dec_hours;
  logic [6:0]                              dec_mins, dec_secs;
  logic [PW-1:0]                           ss_clamped;
  logic [1:0]                              us_carry;
  logic [rtc_atc_pkg::SecSumWidth-1:0]     sec_total;
  logic [ProdW-1:0]                        tick_prod;
  logic [34:0]                             hour_prod;
  logic [24:0]                             min_prod;
  logic [rtc_atc_pkg::HourSecWidth-1:0]    sec_left;
  logic [7:0]                              bcd_h, bcd_m, bcd_s;

  assign in_tod = s_axis_tdata_i[21:0];
  assign in_ss  = s_axis_tdata_i[37:22];

  assign valid_in = {valid_q, s_axis_tvalid_i};

  always_comb begin
    en[NumStages+1] = m_axis_tready_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];

  always_comb begin
    // Stage 1: clamp the subsecond counter and decode the BCD time.
    s1_clamp_d   = in_ss > 16'(Presc);
    ss_clamped   = s1_clamp_d ? Presc : in_ss[PW-1:0];
    s1_elapsed_d = Presc - ss_clamped;
    s1_ds_d      = s_axis_tdata_i[54:38];
    s1_dus_d     = s_axis_tdata_i[74:55];
    dec_hours    = 6'(in_tod[21:20]) * 6'd10 + 6'(in_tod[19:16]);
    dec_mins     = 7'(in_tod[14:12]) * 7'd10 + 7'(in_tod[11:8]);
    dec_secs     = 7'(in_tod[6:4]) * 7'd10 + 7'(in_tod[3:0]);
    s1_todsec_d  = 18'(dec_hours) * 18'd3600 + 18'(dec_mins) * 18'd60 + 18'(dec_secs);

    // Stage 2: elapsed microseconds plus delay, and whole seconds plus delay.
    s2_us_d     = 21'(s1_elapsed_q) * UptC + 21'(s1_dus_q);
    s2_secsum_d = 19'(s1_todsec_q) + 19'(s1_ds_q);

    // Stage 3: carry whole seconds and reduce modulo one day.
    if (s2_us_q >= 21'(2 * rtc_atc_pkg::MicrosPerSecI)) begin
      us_carry   = 2'd2;
      s3_usrem_d = 20'(s2_us_q - 21'(2 * rtc_atc_pkg::MicrosPerSecI));
    end else if (s2_us_q >= rtc_atc_pkg::MicrosPerSec) begin
      us_carry   = 2'd1;
      s3_usrem_d = 20'(s2_us_q - rtc_atc_pkg::MicrosPerSec);
    end else begin
      us_carry   = 2'd0;
      s3_usrem_d = 20'(s2_us_q);
    end
    sec_total = s2_secsum_q + 19'(us_carry);
    if (sec_total >= 19'(3 * 86400)) begin
      s3_sec_d = 17'(sec_total - 19'(3 * 86400));
    end else if (sec_total >= 19'(2 * 86400)) begin
      s3_sec_d = 17'(sec_total - 19'(2 * 86400));
    end else if (sec_total >= rtc_atc_pkg::SecondsPerDay) begin
      s3_sec_d = 17'(sec_total - rtc_atc_pkg::SecondsPerDay);
    end else begin
      s3_sec_d = 17'(sec_total);
    end

    // Stage 4: hours of the day and subsecond ticks by exact reciprocals.
    hour_prod  = 35'(s3_sec_q) * 35'(rtc_atc_pkg::RecipHour);
    s4_hours_d = 5'(hour_prod >> rtc_atc_pkg::ShiftHour);
    tick_prod  = ProdW'(s3_usrem_q) * RecipMC;
    s4_ticks_d = 20'(tick_prod >> RecipK);

    // Stage 5: seconds within the hour and the saturated down-counter value.
    s5_rem_d = 12'(s4_sec_q - 17'(s4_hours_q) * 17'd3600);
    if (s4_ticks_q > 20'(Presc)) begin
      s5_sub_d = '0;
    end else begin
      s5_sub_d = Presc - s4_ticks_q[PW-1:0];
    end

    // Stage 6: minutes within the hour.
    min_prod = 25'(s5_rem_q) * 25'(rtc_atc_pkg::RecipMin);
    s6_min_d = 6'(min_prod >> rtc_atc_pkg::ShiftMin);

    // Stage 7: BCD encoding and mask bits.
    sec_left  = s6_rem_q - 12'(s6_min_q) * 12'd60;
    bcd_h     = rtc_atc_pkg::to_bcd(6'(s6_hours_q));
    bcd_m     = rtc_atc_pkg::to_bcd(s6_min_q);
    bcd_s     = rtc_atc_pkg::to_bcd(sec_left[5:0]);
    s7_time_d = {bcd_h, bcd_m, bcd_s} | rtc_atc_pkg::TimeMaskBits;
    s7_sub_d  = 28'(s6_sub_q) | rtc_atc_pkg::SubMaskBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_elapsed_q <= s1_elapsed_d;
      s1_dus_q     <= s1_dus_d;
      s1_ds_q      <= s1_ds_d;
      s1_todsec_q  <= s1_todsec_d;
      s1_clamp_q   <= s1_clamp_d;
    end
    if (en[2]) begin
      s2_us_q     <= s2_us_d;
      s2_secsum_q <= s2_secsum_d;
      s2_clamp_q  <= s1_clamp_q;
    end
    if (en[3]) begin
      s3_sec_q   <= s3_sec_d;
      s3_usrem_q <= s3_usrem_d;
      s3_clamp_q <= s2_clamp_q;
    end
    if (en[4]) begin
      s4_hours_q <= s4_hours_d;
      s4_sec_q   <= s3_sec_q;
      s4_ticks_q <= s4_ticks_d;
      s4_clamp_q <= s3_clamp_q;
    end
    if (en[5]) begin
      s5_rem_q   <= s5_rem_d;
      s5_hours_q <= s4_hours_q;
      s5_sub_q   <= s5_sub_d;
      s5_clamp_q <= s4_clamp_q;
    end
    if (en[6]) begin
      s6_min_q   <= s6_min_d;
      s6_rem_q   <= s5_rem_q;
      s6_hours_q <= s5_hours_q;
      s6_sub_q   <= s5_sub_q;
      s6_clamp_q <= s5_clamp_q;
    end
    if (en[7]) begin
      s7_time_q  <= s7_time_d;
      s7_sub_q   <= s7_sub_d;
      s7_clamp_q <= s6_clamp_q;
    end
  end

  assign m_axis_tvalid_o = valid_q[NumStages];
  assign m_axis_tdata_o  = {4'd0, s7_sub_q, s7_time_q};
  assign m_axis_tuser_o  = s7_clamp_q;

  // The input side only stalls once every stage is full behind a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready_o |-> (&valid_q) && !m_axis_tready_i)
    else $error("Input stalled while the pipeline still had room.");

  // Every delivered alarm word carries its mask bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> m_axis_tdata_o[23] && m_axis_tdata_o[15] && m_axis_tdata_o[7]
                          && (m_axis_tdata_o[51:48] == 4'hf))
    else $error("Alarm word is missing its mask bits.");

  // The alarm time lies within one day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> (m_axis_tdata_o[21:20] < 2'd2)
                          || ((m_axis_tdata_o[21:20] == 2'd2) && (m_axis_tdata_o[19:16] < 4'd4)))
    else $error("Alarm hour is beyond the end of the day.");

endmodule

[verif/rtc_alarm_checker.sv]
// Checker for the RTC alarm time calculator: predicts each alarm item and compares it.
module rtc_alarm_checker #(
  parameter int TICKS_PER_SECOND = 20000
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  input  logic                                  s_axis_tready_i,
  // Fields from bit 0: current_time_bcd[21:0], current_subsecond[37:22],
  // delay_seconds[54:38], delay_microseconds[74:55], zero fill[79:75].
  input  logic [rtc_atc_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  input  logic                                  m_axis_tvalid_i,
  input  logic                                  m_axis_tready_i,
  // Fields from bit 0: alarm_time_word[23:0], alarm_subsecond_word[51:24],
  // zero fill[55:52].
  input  logic [rtc_atc_pkg::OutDataWidth-1:0] m_axis_tdata_i,
  // Fields from bit 0: input_clamped[0].
  input  logic                                  m_axis_tuser_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeW = rtc_atc_pkg::AlarmTimeWidth;
  localparam int SubW  = rtc_atc_pkg::AlarmSubWidth;

  typedef struct packed {
    logic [TimeW-1:0] time_word;
    logic [SubW-1:0]  sub_word;
    logic             clamped;
  } alarm_t;

  alarm_t alarm_queue[$];
  alarm_t want;
  int     mismatches;

  function automatic alarm_t calc_alarm(input logic [rtc_atc_pkg::InDataWidth-1:0] req);
    int unsigned presc, us_per_tick, sub_now, hrs, mins, secs, day_s, us, ticks, sub;
    alarm_t res;
    presc       = TICKS_PER_SECOND - 1;
    us_per_tick = 1000000 / TICKS_PER_SECOND;
    sub_now     = req[37:22];
    res.clamped = (sub_now > presc);
    if (res.clamped) begin
      sub_now = presc;
    end
    hrs   = req[21:20];
    hrs   = hrs * 10 + req[19:16];
    mins  = req[14:12];
    mins  = mins * 10 + req[11:8];
    secs  = req[6:4];
    secs  = secs * 10 + req[3:0];
    day_s = hrs * 3600 + mins * 60 + secs + req[54:38];
    us    = (presc - sub_now) * us_per_tick + req[74:55];
    day_s = (day_s + us / 1000000) % 86400;
    us    = us % 1000000;
    ticks = us / us_per_tick;
    sub   = (ticks > presc) ? 0 : presc - ticks;
    res.time_word = TimeW'(((day_s / 36000) << 20) | (((day_s / 3600) % 10) << 16) |
                           (((day_s % 3600) / 600) << 12) |
                           (((day_s % 600) / 60) << 8) |
                           (((day_s % 60) / 10) << 4) | (day_s % 10))
                    | rtc_atc_pkg::TimeMaskBits;
    res.sub_word  = SubW'(sub) | rtc_atc_pkg::SubMaskBits;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_queue.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        alarm_queue.push_back(calc_alarm(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (alarm_queue.size() == 0) begin
          $display("%0t: unexpected alarm item %h, user %b", $time, m_axis_tdata_i,
                   m_axis_tuser_i);
          mismatches++;
        end else begin
          want = alarm_queue.pop_front();
          if (m_axis_tdata_i[23:0] !== want.time_word) begin
            $display("%0t: alarm time word expected %h, got %h", $time, want.time_word,
                     m_axis_tdata_i[23:0]);
            mismatches++;
          end
          if (m_axis_tdata_i[51:24] !== want.sub_word) begin
            $display("%0t: alarm subsecond word expected %h, got %h", $time, want.sub_word,
                     m_axis_tdata_i[51:24]);
            mismatches++;
          end
          if (m_axis_tuser_i !== want.clamped) begin
            $display("%0t: clamp flag expected %b, got %b", $time, want.clamped,
                     m_axis_tuser_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= alarm_queue.size();
    end
  end

endmodule

[verif/rtc_alarm_time_calculator_test.sv]
// Testbench top for the RTC alarm time calculator: stimulus, handshake pacing and verdict.
module rtc_alarm_time_calculator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Ticks         = 20000;
  localparam int ItemsPerPhase = 400;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  s_tvalid;
  logic                                  s_tready;
  logic [rtc_atc_pkg::InDataWidth-1:0]  s_tdata;
  logic                                  m_tvalid;
  logic                                  m_tready;
  logic [rtc_atc_pkg::OutDataWidth-1:0] m_tdata;
  logic                                  m_tuser;
  int                                    fail_count;
  int                                    pending;
  int                                    send_idle_pct;
  int                                    recv_stall_pct;
  int                                    hold_left;

  rtc_alarm_time_calculator #(
    .SUBSECOND_TICKS_PER_SECOND(Ticks)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  rtc_alarm_checker #(
    .TICKS_PER_SECOND(Ticks)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [rtc_atc_pkg::InDataWidth-1:0] pack_request(
      input logic [21:0] tod,
      input logic [15:0] sub_now,
      input logic [16:0] dsec,
      input logic [19:0] dus);
    return {5'd0, dus, dsec, sub_now, tod};
  endfunction

  function automatic logic [rtc_atc_pkg::InDataWidth-1:0] random_request();
    int unsigned pick, hrs, mins, secs;
    logic [21:0] tod;
    logic [15:0] sub_now;
    logic [16:0] dsec;
    logic [19:0] dus;
    pick = $urandom_range(99);
    hrs  = $urandom_range(23);
    mins = $urandom_range(59);
    secs = $urandom_range(59);
    tod  = {2'(hrs / 10), 4'(hrs % 10), 1'($urandom), 3'(mins / 10), 4'(mins % 10),
            1'($urandom), 3'(secs / 10), 4'(secs % 10)};
    if (pick < 70) begin
      sub_now = 16'($urandom_range(Ticks - 1));
      dsec    = 17'($urandom_range(86399));
      dus     = 20'($urandom_range(999999));
    end else if (pick < 85) begin
      tod     = 22'($urandom);
      sub_now = 16'($urandom);
      dsec    = 17'($urandom);
      dus     = 20'($urandom);
    end else begin
      case ($urandom_range(3))
        0: sub_now = 16'd0;
        1: sub_now = 16'(Ticks - 1);
        2: sub_now = 16'(Ticks);
        default: sub_now = 16'hffff;
      endcase
      case ($urandom_range(3))
        0: dsec = 17'd0;
        1: dsec = 17'd86399;
        2: dsec = 17'd86400;
        default: dsec = 17'h1ffff;
      endcase
      case ($urandom_range(3))
        0: dus = 20'd0;
        1: dus = 20'd999999;
        2: dus = 20'd1000000;
        default: dus = 20'hfffff;
      endcase
      if ($urandom_range(1) == 0) begin
        tod = 22'h235959;
      end
    end
    return pack_request(tod, sub_now, dsec, dus);
  endfunction

  task automatic send_item(input logic [rtc_atc_pkg::InDataWidth-1:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk_i);
    while (!s_tready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(pack_request(22'h000000, 16'd0, 17'd0, 20'd0));
    send_item(pack_request(22'h235959, 16'd0, 17'd0, 20'd0));
    send_item(pack_request(22'h235959, 16'(Ticks - 1), 17'd1, 20'd0));
    send_item(pack_request(22'h000000, 16'(Ticks), 17'd0, 20'd0));
    send_item(pack_request(22'h000000, 16'hffff, 17'd0, 20'd0));
    send_item(pack_request(22'h120000, 16'd0, 17'd0, 20'd999999));
    send_item(pack_request(22'h120000, 16'd0, 17'd86399, 20'hfffff));
    send_item(pack_request(22'h3fffff, 16'hffff, 17'h1ffff, 20'hfffff));
    send_item(pack_request(22'h1f8f8f, 16'd1, 17'd0, 20'd0));
    send_item(pack_request(22'h008080, 16'd10000, 17'd0, 20'd0));
    send_item(pack_request(22'h000000, 16'(Ticks - 1), 17'd86399, 20'd999999));
    send_item(pack_request(22'h235959, 16'd12345, 17'd86400, 20'd1000000));
    send_item(pack_request(22'h0a5a5a, 16'h5555, 17'h0aaaa, 20'h55555));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_left      = 300;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 50;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_item(random_request());
      end
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
